/* rtl/core/adam_weight_update_assert.svh */
// ----------------------------------------------------------------------------
// Adam weight update - assertion macros
// Clocked on clk, switched off while rst is high.
// ----------------------------------------------------------------------------
`ifndef ADAM_WEIGHT_UPDATE_ASSERT_SVH
`define ADAM_WEIGHT_UPDATE_ASSERT_SVH

// same-cycle implication
`define AWU_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("adam_weight_update: check failed");

// next-cycle implication
`define AWU_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("adam_weight_update: check failed");

`endif

/* rtl/core/awu_pkg.sv */
// ----------------------------------------------------------------------------
// Adam weight update - shared package
// Register indices, datapath widths and the shift-subtract unit's types.
// ----------------------------------------------------------------------------
`default_nettype none

package awu_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_DECAY_FIRST   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_SECOND  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STABILIZER    = 2'd3;

  localparam logic [15:0] DECAY_FIRST_RST   = 16'd58982;
  localparam logic [15:0] DECAY_SECOND_RST  = 16'd65470;
  localparam logic [31:0] LEARNING_RATE_RST = 32'd66;
  localparam logic [31:0] STABILIZER_RST    = 32'd429;

  // shared multiplier: signed 34 x 33
  localparam int unsigned MUL_A_W = 34;
  localparam int unsigned MUL_B_W = 33;
  localparam int unsigned MUL_P_W = 67;

  // shift-subtract unit
  localparam int unsigned NUM_W  = 80;
  localparam int unsigned DVS_W  = 58;
  localparam int unsigned QUO_W  = 64;
  localparam int unsigned STEP_W = 7;
  localparam logic [STEP_W-1:0] DIV_STEPS  = 7'd80;
  localparam logic [STEP_W-1:0] SQRT_STEPS = 7'd40;

  localparam logic [QUO_W-1:0] VHAT_CAP = 64'h4000_0000_0000_0000;
  localparam logic [QUO_W-1:0] STEP_CAP = 64'h0000_0100_0000_0000;

  typedef enum logic [0:0] {
    ITER_DIV  = 1'b0,
    ITER_SQRT = 1'b1
  } iter_mode_t;

  typedef struct packed {
    logic       start;
    iter_mode_t mode;
  } iter_ctl_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } iter_sts_t;

endpackage

`default_nettype wire

/* rtl/core/awu_ram.sv */
// ----------------------------------------------------------------------------
// Adam weight update - generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module awu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire              clk,
  input  wire              we,
  input  wire [AW-1:0]     waddr,
  input  wire [WIDTH-1:0]  wdata,
  input  wire              re,
  input  wire [AW-1:0]     raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/awu_mul.sv */
// ----------------------------------------------------------------------------
// Adam weight update - shared multiplier
// Signed 34 x 33 product, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module awu_mul (
  input  wire                                 clk,
  input  wire signed [awu_pkg::MUL_A_W-1:0]   a,
  input  wire signed [awu_pkg::MUL_B_W-1:0]   b,
  output logic signed [awu_pkg::MUL_P_W-1:0]  prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

`default_nettype wire

/* rtl/core/awu_iter.sv */
// ----------------------------------------------------------------------------
// Adam weight update - shift-subtract unit
// Restoring division (one quotient bit a cycle) or integer square root
// (one root bit a cycle) through one shared compare-and-subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module awu_iter (
  input  wire                              clk,
  input  wire                              rst,
  input  wire awu_pkg::iter_ctl_t          ctl,
  input  wire [awu_pkg::NUM_W-1:0]         num,
  input  wire [awu_pkg::DVS_W-1:0]         dvs,
  output logic [awu_pkg::QUO_W-1:0]        quo,
  output awu_pkg::iter_sts_t               sts
);

  localparam int unsigned NW = awu_pkg::NUM_W;
  localparam int unsigned DW = awu_pkg::DVS_W;
  localparam int unsigned QW = awu_pkg::QUO_W;

  logic                        busy_i;
  logic                        done_r;
  logic [awu_pkg::STEP_W-1:0]  cnt;
  logic [NW-1:0]               nr;
  logic [DW-1:0]               rem;
  logic [QW-1:0]               q;
  logic                        sticky;
  awu_pkg::iter_mode_t         mode_r;

  logic [DW:0]   cand;
  logic [DW:0]   deff;
  logic [DW+1:0] diff;
  logic          ge;

  always_comb begin
    if (mode_r == awu_pkg::ITER_SQRT) begin
      // bring down two radicand bits, trial is 4*root + 1
      cand = {rem[DW-2:0], nr[NW-1 -: 2]};
      deff = {q[DW-2:0], 2'b01};
    end else begin
      cand = {rem, nr[NW-1]};
      deff = {1'b0, dvs};
    end
    diff = {1'b0, cand} - {1'b0, deff};
    ge   = ~diff[DW+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_i <= 1'b0;
      done_r <= 1'b0;
      cnt    <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_i <= 1'b1;
        cnt    <= (ctl.mode == awu_pkg::ITER_SQRT) ? awu_pkg::SQRT_STEPS
                                                   : awu_pkg::DIV_STEPS;
      end else if (busy_i) begin
        cnt <= cnt - 1'b1;
        if (cnt == awu_pkg::STEP_W'(1)) begin
          busy_i <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      nr     <= num;
      rem    <= '0;
      q      <= '0;
      sticky <= 1'b0;
      mode_r <= ctl.mode;
    end else if (busy_i) begin
      nr     <= (mode_r == awu_pkg::ITER_SQRT) ? {nr[NW-3:0], 2'b00} : {nr[NW-2:0], 1'b0};
      rem    <= ge ? diff[DW-1:0] : cand[DW-1:0];
      q      <= {q[QW-2:0], ge};
      // quotient bits pushed off the top mean the result is past any cap
      sticky <= sticky | q[QW-1];
    end
  end

  assign quo      = q;
  assign sts.done = done_r;
  assign sts.ovf  = sticky;

endmodule

`default_nettype wire

/* rtl/core/adam_weight_update.sv */
// ----------------------------------------------------------------------------
// Adam weight update - top level
// Per word: start is taken when busy is low; one result word follows, shown
// for one cycle with done, and the receiver cannot stall it. A word with
// epoch zero gives its error result in the next cycle and leaves busy low.
// Any other word holds busy until its result: three passes of the shift-subtract
// unit (80, 40 and 80 steps) take most of that time, the two bias-correction
// powers through the one multiplier the rest. Each power squares once for each
// bit of epoch below its top set bit and multiplies once for each set bit below
// it. After reset the moment RAMs are zeroed one slot a cycle with busy high;
// configuration writes are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "adam_weight_update_assert.svh"

module adam_weight_update #(
  parameter int unsigned SLOT_COUNT = 1024
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cfg_write,
  input  wire [awu_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire [awu_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire                                 start,
  output logic                                busy,
  input  wire [9:0]                           slot_index,
  input  wire signed [31:0]                   gradient,
  input  wire signed [31:0]                   weight_before,
  input  wire [15:0]                          epoch,
  output logic                                done,
  output logic signed [31:0]                  weight_after,
  output logic signed [31:0]                  weight_change,
  output logic                                epoch_zero_error
);

  localparam int unsigned ADDR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [26:0] SLOTS_WIDE = 27'(SLOT_COUNT);
  localparam logic [ADDR_W:0] LAST_SLOT = (ADDR_W+1)'(SLOT_COUNT - 1);

  typedef enum logic [29:0] {
    S_IDLE  = 30'd1 << 0,
    S_CLEAR = 30'd1 << 1,
    S_MOD   = 30'd1 << 2,
    S_RD    = 30'd1 << 3,
    S_M1A   = 30'd1 << 4,
    S_M1B   = 30'd1 << 5,
    S_M1C   = 30'd1 << 6,
    S_M2A   = 30'd1 << 7,
    S_M2B   = 30'd1 << 8,
    S_M2C   = 30'd1 << 9,
    S_M2D   = 30'd1 << 10,
    S_M2E   = 30'd1 << 11,
    S_PWI   = 30'd1 << 12,
    S_PWS   = 30'd1 << 13,
    S_PWSW  = 30'd1 << 14,
    S_PWM   = 30'd1 << 15,
    S_PWMW  = 30'd1 << 16,
    S_PWN   = 30'd1 << 17,
    S_PWE   = 30'd1 << 18,
    S_VDIV  = 30'd1 << 19,
    S_VWAIT = 30'd1 << 20,
    S_RDIV  = 30'd1 << 21,
    S_RWAIT = 30'd1 << 22,
    S_DA    = 30'd1 << 23,
    S_DB    = 30'd1 << 24,
    S_DC    = 30'd1 << 25,
    S_NM    = 30'd1 << 26,
    S_UWAIT = 30'd1 << 27,
    S_FIN   = 30'd1 << 28,
    S_OUT   = 30'd1 << 29
  } state_t;

  function automatic logic [3:0] top_bit(input logic [15:0] v);
    logic [3:0] pos;
    pos = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) pos = 4'(i);
    end
    return pos;
  endfunction

  state_t state;
  logic [ADDR_W:0] clr_cnt;

  logic [15:0] d1;
  logic [15:0] d2;
  logic [31:0] lr;
  logic [31:0] stab;

  logic [9:0]         slot;
  logic signed [31:0] g;
  logic signed [31:0] w;
  logic [15:0]        t;
  logic [3:0]         kcnt;
  logic signed [67:0] acc;
  logic signed [31:0] m1;
  logic [47:0]        m2;
  logic [46:0]        gsq;
  logic [31:0]        p;
  logic               pw_sel;
  logic [32:0]        q1;
  logic [32:0]        q2;
  logic [62:0]        vhat;
  logic [39:0]        root;
  logic [57:0]        den;
  logic [40:0]        umag;
  logic signed [31:0] after_r;

  logic signed [awu_pkg::MUL_A_W-1:0] mul_a;
  logic signed [awu_pkg::MUL_B_W-1:0] mul_b;
  logic signed [awu_pkg::MUL_P_W-1:0] prod;

  awu_pkg::iter_ctl_t            ictl;
  awu_pkg::iter_sts_t            ists;
  logic [awu_pkg::NUM_W-1:0]     inum;
  logic [awu_pkg::DVS_W-1:0]     idvs;
  logic [awu_pkg::QUO_W-1:0]     iquo;

  logic              ram_we;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_waddr;
  logic [31:0]       fm_wdata;
  logic [47:0]       sm_wdata;
  logic [31:0]       fm_rd;
  logic [47:0]       sm_rd;

  logic [16:0]  c1;
  logic [16:0]  c2;
  logic [31:0]  base32;
  logic [67:0]  sum1;
  logic [67:0]  sum2;
  logic [47:0]  m2_new;
  logic [55:0]  den1;
  logic [57:0]  dsum;
  logic [31:0]  m1mag;
  logic [26:0]  cmpv;
  logic [3:0]   topb;
  logic [32:0]  qv;
  logic [63:0]  ucap;
  logic [63:0]  vcap;
  logic signed [41:0] u;
  logic signed [42:0] wdiff;
  logic signed [32:0] chg;
  logic [31:0]  after_sat;
  logic [31:0]  chg_sat;

  always_comb begin
    c1     = 17'h10000 - {1'b0, d1};
    c2     = 17'h10000 - {1'b0, d2};
    base32 = {(pw_sel ? d2 : d1), 16'h0000};
    sum1   = acc + 68'(prod);
    sum2   = acc + {prod[35:0], 32'h0};
    m2_new = sum2[63:16];
    den1   = 56'({root, 16'h0000}) + 56'(stab);
    dsum   = acc[57:0] + {23'b0, prod[66:32]};
    m1mag  = m1[31] ? 32'(-m1) : m1;
    cmpv   = SLOTS_WIDE << kcnt;
    topb   = top_bit(t);
    qv     = 33'h1_0000_0000 - {1'b0, p};
    vcap   = (ists.ovf || iquo > awu_pkg::VHAT_CAP) ? awu_pkg::VHAT_CAP : iquo;
    ucap   = (ists.ovf || iquo > awu_pkg::STEP_CAP) ? awu_pkg::STEP_CAP : iquo;
    u      = m1[31] ? -$signed({1'b0, umag}) : $signed({1'b0, umag});
    wdiff  = 43'(w) - 43'(u);
    chg    = 33'(after_r) - 33'(w);

    if (!wdiff[42] && (|wdiff[41:31])) after_sat = 32'h7FFF_FFFF;
    else if (wdiff[42] && !(&wdiff[41:31])) after_sat = 32'h8000_0000;
    else after_sat = wdiff[31:0];

    if (chg[32] != chg[31]) chg_sat = chg[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else chg_sat = chg[31:0];
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_M1A: begin
        mul_a = {18'b0, d1};
        mul_b = {fm_rd[31], fm_rd};
      end
      S_M1B: begin
        mul_a = {17'b0, c1};
        mul_b = {g[31], g};
      end
      S_M1C: begin
        mul_a = {{2{g[31]}}, g};
        mul_b = {g[31], g};
      end
      S_M2A: begin
        mul_a = {18'b0, d2};
        mul_b = {1'b0, sm_rd[31:0]};
      end
      S_M2B: begin
        mul_a = {18'b0, d2};
        mul_b = {17'b0, sm_rd[47:32]};
      end
      S_M2C: begin
        mul_a = {17'b0, c2};
        mul_b = {1'b0, gsq[31:0]};
      end
      S_M2D: begin
        mul_a = {17'b0, c2};
        mul_b = {18'b0, gsq[46:32]};
      end
      S_PWS: begin
        mul_a = {2'b00, p};
        mul_b = {1'b0, p};
      end
      S_PWM: begin
        mul_a = {2'b00, p};
        mul_b = {1'b0, base32};
      end
      S_DA: begin
        mul_a = {1'b0, q1};
        mul_b = {9'b0, den1[55:32]};
      end
      S_DB: begin
        mul_a = {1'b0, q1};
        mul_b = {1'b0, den1[31:0]};
      end
      S_DC: begin
        mul_a = {2'b00, lr};
        mul_b = {1'b0, m1mag};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    ictl.start = (state == S_VDIV) || (state == S_RDIV) || (state == S_NM);
    ictl.mode  = (state == S_RDIV) ? awu_pkg::ITER_SQRT : awu_pkg::ITER_DIV;
    case (state)
      S_VDIV:  inum = {m2, 32'h0};
      S_RDIV:  inum = {1'b0, vhat, 16'h0000};
      S_NM:    inum = {1'b0, prod[62:0], 16'h0000};
      default: inum = '0;
    endcase
    idvs = ((state == S_NM) || (state == S_UWAIT)) ? den : {25'b0, q2};
  end

  always_comb begin
    ram_we    = (state == S_CLEAR) || (state == S_M2E);
    ram_re    = (state == S_RD);
    ram_waddr = (state == S_CLEAR) ? clr_cnt[ADDR_W-1:0] : ADDR_W'(slot);
    fm_wdata  = (state == S_CLEAR) ? 32'h0 : m1;
    sm_wdata  = (state == S_CLEAR) ? 48'h0 : m2_new;
  end

  assign busy = (state != S_IDLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      d1   <= awu_pkg::DECAY_FIRST_RST;
      d2   <= awu_pkg::DECAY_SECOND_RST;
      lr   <= awu_pkg::LEARNING_RATE_RST;
      stab <= awu_pkg::STABILIZER_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        awu_pkg::REG_DECAY_FIRST:   d1   <= cfg_data[15:0];
        awu_pkg::REG_DECAY_SECOND:  d2   <= cfg_data[15:0];
        awu_pkg::REG_LEARNING_RATE: lr   <= cfg_data;
        awu_pkg::REG_STABILIZER:    stab <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == LAST_SLOT) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            slot <= slot_index;
            g    <= gradient;
            w    <= weight_before;
            t    <= epoch;
            kcnt <= 4'd9;
            if (epoch == 16'd0) begin
              done             <= 1'b1;
              weight_after     <= weight_before;
              weight_change    <= 32'sd0;
              epoch_zero_error <= 1'b1;
            end else begin
              state <= S_MOD;
            end
          end
        end
        S_MOD: begin
          // slot index folded into range, one shifted subtract a cycle
          if ({17'b0, slot} >= cmpv) slot <= slot - cmpv[9:0];
          if (kcnt == 4'd0) state <= S_RD;
          else kcnt <= kcnt - 1'b1;
        end
        S_RD:  state <= S_M1A;
        S_M1A: state <= S_M1B;
        S_M1B: begin
          acc   <= 68'(prod);
          state <= S_M1C;
        end
        S_M1C: begin
          m1    <= sum1[47:16];
          state <= S_M2A;
        end
        S_M2A: begin
          gsq   <= prod[62:16];
          state <= S_M2B;
        end
        S_M2B: begin
          acc   <= 68'(prod);
          state <= S_M2C;
        end
        S_M2C: begin
          acc   <= sum2;
          state <= S_M2D;
        end
        S_M2D: begin
          acc   <= sum1;
          state <= S_M2E;
        end
        S_M2E: begin
          m2     <= m2_new;
          pw_sel <= 1'b0;
          state  <= S_PWI;
        end
        S_PWI: begin
          p    <= base32;
          kcnt <= topb - 1'b1;
          state <= (topb == 4'd0) ? S_PWE : S_PWS;
        end
        S_PWS: state <= S_PWSW;
        S_PWSW: begin
          p     <= prod[63:32];
          state <= t[kcnt] ? S_PWM : S_PWN;
        end
        S_PWM: state <= S_PWMW;
        S_PWMW: begin
          p     <= prod[63:32];
          state <= S_PWN;
        end
        S_PWN: begin
          if (kcnt == 4'd0) begin
            state <= S_PWE;
          end else begin
            kcnt  <= kcnt - 1'b1;
            state <= S_PWS;
          end
        end
        S_PWE: begin
          if (!pw_sel) begin
            q1     <= qv;
            pw_sel <= 1'b1;
            state  <= S_PWI;
          end else begin
            q2    <= qv;
            state <= S_VDIV;
          end
        end
        S_VDIV: state <= S_VWAIT;
        S_VWAIT: begin
          if (ists.done) begin
            vhat  <= vcap[62:0];
            state <= S_RDIV;
          end
        end
        S_RDIV: state <= S_RWAIT;
        S_RWAIT: begin
          if (ists.done) begin
            root  <= iquo[39:0];
            state <= S_DA;
          end
        end
        S_DA: state <= S_DB;
        S_DB: begin
          acc   <= 68'(prod);
          state <= S_DC;
        end
        S_DC: begin
          den   <= (dsum == 58'd0) ? 58'd1 : dsum;
          state <= S_NM;
        end
        S_NM: state <= S_UWAIT;
        S_UWAIT: begin
          if (ists.done) begin
            umag  <= ucap[40:0];
            state <= S_FIN;
          end
        end
        S_FIN: begin
          after_r <= after_sat;
          state   <= S_OUT;
        end
        S_OUT: begin
          done             <= 1'b1;
          weight_after     <= after_r;
          weight_change    <= chg_sat;
          epoch_zero_error <= 1'b0;
          state            <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  awu_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  awu_iter u_iter (
    .clk (clk),
    .rst (rst),
    .ctl (ictl),
    .num (inum),
    .dvs (idvs),
    .quo (iquo),
    .sts (ists)
  );

  awu_ram #(
    .WIDTH (32),
    .DEPTH (SLOT_COUNT),
    .AW    (ADDR_W)
  ) u_first_moment (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (fm_wdata),
    .re    (ram_re),
    .raddr (ADDR_W'(slot)),
    .rdata (fm_rd)
  );

  awu_ram #(
    .WIDTH (48),
    .DEPTH (SLOT_COUNT),
    .AW    (ADDR_W)
  ) u_second_moment (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (sm_wdata),
    .re    (ram_re),
    .raddr (ADDR_W'(slot)),
    .rdata (sm_rd)
  );

  `AWU_ASSERT_NEXT(a_zero_epoch, start && !busy && epoch == 16'd0, done && epoch_zero_error && weight_change == 32'sd0)
  `AWU_ASSERT_NOW(a_iter_done_waited, ists.done, state == S_VWAIT || state == S_RWAIT || state == S_UWAIT)
  `AWU_ASSERT_NOW(a_ram_write_state, ram_we, state == S_CLEAR || state == S_M2E)
  `AWU_ASSERT_NEXT(a_result_after_out, state == S_OUT, done && !epoch_zero_error && !busy)

endmodule

`default_nettype wire
